FILE: hw/rtl/mesh_area_volume_bounds_assert.svh
// Assertion macros shared by the mesh area/volume block.
`ifndef MESH_AREA_VOLUME_BOUNDS_ASSERT_SVH
`define MESH_AREA_VOLUME_BOUNDS_ASSERT_SVH
`ifndef SYNTHESIS
`define MAVB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define MAVB_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition");
`else
`define MAVB_ASSERT(label, clk, rst, prop)
`define MAVB_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: hw/rtl/mavb_pkg.sv
`timescale 1ns / 1ps
package mavb_pkg;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd17;

   localparam logic [62:0] MAG_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam int VOL_HALF = 12288;
   localparam int VOL_SHIFT = 13;

   // first operand sources
   localparam logic [1:0] SRC_E1 = 2'd0;
   localparam logic [1:0] SRC_B = 2'd1;
   localparam logic [1:0] SRC_N = 2'd2;

   // second operand sources
   localparam logic [1:0] OPB_E2 = 2'd0;
   localparam logic [1:0] OPB_C = 2'd1;
   localparam logic [1:0] OPB_A = 2'd2;
   localparam logic [1:0] OPB_SAME = 2'd3;

   // write-back targets
   localparam logic [2:0] DST_NONE = 3'd0;
   localparam logic [2:0] DST_N0 = 3'd1;
   localparam logic [2:0] DST_N1 = 3'd2;
   localparam logic [2:0] DST_N2 = 3'd3;
   localparam logic [2:0] DST_NSQ = 3'd4;

   typedef struct packed {
      logic [1:0] src_a;
      logic [1:0] idx_a;
      logic [1:0] src_b;
      logic [1:0] idx_b;
      logic       neg;
      logic       clr;
      logic [2:0] dst;
   } step_type;

   typedef struct packed {
      logic              load;
      logic              mul_load;
      logic              mul_run;
      logic              mul_wb;
      logic              sqrt_init;
      logic              sqrt_run;
      logic              div_init;
      logic              div_run;
      logic              acc;
      logic              emit;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } status_type;

   function automatic step_type make_step(input logic [1:0] sa, input logic [1:0] ia,
                                          input logic [1:0] sb, input logic [1:0] ib,
                                          input logic neg, input logic clr,
                                          input logic [2:0] dst);
      step_type s;
      s.src_a = sa;
      s.idx_a = ia;
      s.src_b = sb;
      s.idx_b = ib;
      s.neg = neg;
      s.clr = clr;
      s.dst = dst;
      return s;
   endfunction

   // edge cross product, its squared length, vertex cross product, triple product
   function automatic step_type step_info(input logic [STEP_W-1:0] s);
      step_type r;
      case (s)
         5'd0:  r = make_step(SRC_E1, 2'd1, OPB_E2, 2'd2, 1'b0, 1'b1, DST_NONE);
         5'd1:  r = make_step(SRC_E1, 2'd2, OPB_E2, 2'd1, 1'b1, 1'b0, DST_N0);
         5'd2:  r = make_step(SRC_E1, 2'd2, OPB_E2, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd3:  r = make_step(SRC_E1, 2'd0, OPB_E2, 2'd2, 1'b1, 1'b0, DST_N1);
         5'd4:  r = make_step(SRC_E1, 2'd0, OPB_E2, 2'd1, 1'b0, 1'b1, DST_NONE);
         5'd5:  r = make_step(SRC_E1, 2'd1, OPB_E2, 2'd0, 1'b1, 1'b0, DST_N2);
         5'd6:  r = make_step(SRC_N, 2'd0, OPB_SAME, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd7:  r = make_step(SRC_N, 2'd1, OPB_SAME, 2'd0, 1'b0, 1'b0, DST_NONE);
         5'd8:  r = make_step(SRC_N, 2'd2, OPB_SAME, 2'd0, 1'b0, 1'b0, DST_NSQ);
         5'd9:  r = make_step(SRC_B, 2'd1, OPB_C, 2'd2, 1'b0, 1'b1, DST_NONE);
         5'd10: r = make_step(SRC_B, 2'd2, OPB_C, 2'd1, 1'b1, 1'b0, DST_N0);
         5'd11: r = make_step(SRC_B, 2'd2, OPB_C, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd12: r = make_step(SRC_B, 2'd0, OPB_C, 2'd2, 1'b1, 1'b0, DST_N1);
         5'd13: r = make_step(SRC_B, 2'd0, OPB_C, 2'd1, 1'b0, 1'b1, DST_NONE);
         5'd14: r = make_step(SRC_B, 2'd1, OPB_C, 2'd0, 1'b1, 1'b0, DST_N2);
         5'd15: r = make_step(SRC_N, 2'd0, OPB_A, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd16: r = make_step(SRC_N, 2'd1, OPB_A, 2'd1, 1'b0, 1'b0, DST_NONE);
         5'd17: r = make_step(SRC_N, 2'd2, OPB_A, 2'd2, 1'b0, 1'b0, DST_NONE);
         default: r = make_step(SRC_E1, 2'd0, OPB_E2, 2'd0, 1'b0, 1'b0, DST_NONE);
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/mavb_ctrl.sv
`timescale 1ns / 1ps
`include "mesh_area_volume_bounds_assert.svh"
module mavb_ctrl #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mavb_pkg::status_type status,
   output mavb_pkg::cmd_type    cmd
);

   localparam int OW = 2 * COORD_WIDTH + 2;
   localparam int RW = 2 * COORD_WIDTH + 3;
   localparam int XW = 3 * COORD_WIDTH - mavb_pkg::VOL_SHIFT;
   localparam int DIV_CYCLES = $clog2(XW + 1);
   localparam int CNT_W = $clog2(RW + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_RUN = 3'd2;
   localparam logic [2:0] ST_WB = 3'd3;
   localparam logic [2:0] ST_PREP = 3'd4;
   localparam logic [2:0] ST_SQRT = 3'd5;
   localparam logic [2:0] ST_DIV = 3'd6;
   localparam logic [2:0] ST_ACC = 3'd7;

   logic [2:0]                    state_ff, state_in;
   logic [mavb_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   mavb_pkg::step_type            info;

   assign info = mavb_pkg::step_info(step_ff);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      cmd.step = step_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.mul_load = 1'b1;
            cnt_in = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.mul_run = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(OW - 1)) begin
               if (info.dst != mavb_pkg::DST_NONE) begin
                  state_in = ST_WB;
               end else if (step_ff == mavb_pkg::LAST_STEP) begin
                  state_in = ST_PREP;
               end else begin
                  step_in = step_ff + mavb_pkg::STEP_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_WB: begin
            cmd.mul_wb = 1'b1;
            if (step_ff == mavb_pkg::LAST_STEP) begin
               state_in = ST_PREP;
            end else begin
               step_in = step_ff + mavb_pkg::STEP_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_PREP: begin
            cmd.sqrt_init = 1'b1;
            cmd.div_init = 1'b1;
            cnt_in = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_run = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RW - 1)) begin
               cnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_run = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (!status.last || status.out_free) begin
               cmd.acc = 1'b1;
               cmd.emit = status.last;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         cnt_ff <= cnt_in;
      end
   end

   `MAVB_ASSERT(a_accept_starts, clock, reset, (req_tvalid && req_tready) |=> (state_ff == ST_LOAD))
   `MAVB_NEVER(a_step_range, clock, reset, step_ff > mavb_pkg::LAST_STEP)
   `MAVB_NEVER(a_ready_idle, clock, reset, req_tready && (state_ff != ST_IDLE))

endmodule

FILE: hw/rtl/mavb_datapath.sv
`timescale 1ns / 1ps
`include "mesh_area_volume_bounds_assert.svh"
module mavb_datapath #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mavb_pkg::cmd_type            cmd,
   output mavb_pkg::status_type         status,
   input  logic [9*COORD_WIDTH-1:0]     in_data,
   input  logic                         in_last,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [62:0]                  out_area,
   output logic [62:0]                  out_volume,
   output logic [COORD_WIDTH-1:0]       out_min [3],
   output logic [COORD_WIDTH-1:0]       out_max [3],
   output logic                         out_sat
);

   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 1;
   localparam int OW = 2 * CW + 2;
   localparam int AW = 4 * CW + 5;
   localparam int RW = 2 * CW + 3;
   localparam int XW = 3 * CW - mavb_pkg::VOL_SHIFT;
   localparam int DIV_STAGES = $clog2(XW + 1) - 1;
   localparam int KW = 2 << DIV_STAGES;
   localparam int PW = XW + KW;
   localparam int IDX_W = $clog2(DIV_STAGES + 1);

   logic [CW-1:0]  a_ff [3];
   logic [CW-1:0]  b_ff [3];
   logic [CW-1:0]  c_ff [3];
   logic [EW-1:0]  e1_ff [3];
   logic [EW-1:0]  e2_ff [3];
   logic [OW-1:0]  n_ff [3];
   logic [AW-1:0]  nsq_ff;
   logic [AW-1:0]  acc_ff;
   logic [AW-1:0]  mcand_ff;
   logic [OW-1:0]  mplier_ff;
   logic           msub_ff;
   logic           last_ff;
   logic [CW-1:0]  min_ff [3];
   logic [CW-1:0]  max_ff [3];
   logic [CW-1:0]  min_in [3];
   logic [CW-1:0]  max_in [3];
   logic [62:0]    area_ff;
   logic [63:0]    vol_ff;
   logic           sat_ff;
   logic [2*RW-1:0] rad_ff;
   logic [RW+2:0]  rem_ff;
   logic [RW-1:0]  root_ff;
   logic [XW-1:0]  x_ff;
   logic [PW-1:0]  p_ff;
   logic [IDX_W-1:0] div_idx_ff;
   logic           vneg_ff;
   logic           rsp_tvalid_ff;

   mavb_pkg::step_type info;
   logic [OW-1:0]  opa, opb, ma, mb;
   logic [RW+2:0]  r_sh, r_try;
   logic [PW-1:0]  p_add;
   logic [AW-1:0]  vmag, vsum;
   logic [RW:0]    rp;
   logic [AW-1:0]  aext, qext;
   logic           asat, vsat, aclamp, vclamp;
   logic [62:0]    aterm, vterm;
   logic [63:0]    area_sum;
   logic [65:0]    vs;
   logic [62:0]    area_new;
   logic [63:0]    vol_new;
   logic [63:0]    vol_abs;

   localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [65:0] MAX66 = {3'b000, mavb_pkg::MAG_MAX};

   assign info = mavb_pkg::step_info(cmd.step);

   always_comb begin
      case (info.src_a)
         mavb_pkg::SRC_E1: opa = {{(OW-EW){e1_ff[info.idx_a][EW-1]}}, e1_ff[info.idx_a]};
         mavb_pkg::SRC_B:  opa = {{(OW-CW){b_ff[info.idx_a][CW-1]}}, b_ff[info.idx_a]};
         mavb_pkg::SRC_N:  opa = n_ff[info.idx_a];
         default:          opa = '0;
      endcase
      case (info.src_b)
         mavb_pkg::OPB_E2: opb = {{(OW-EW){e2_ff[info.idx_b][EW-1]}}, e2_ff[info.idx_b]};
         mavb_pkg::OPB_C:  opb = {{(OW-CW){c_ff[info.idx_b][CW-1]}}, c_ff[info.idx_b]};
         mavb_pkg::OPB_A:  opb = {{(OW-CW){a_ff[info.idx_b][CW-1]}}, a_ff[info.idx_b]};
         default:          opb = opa;
      endcase
      ma = opa[OW-1] ? (~opa + OW'(1)) : opa;
      mb = opb[OW-1] ? (~opb + OW'(1)) : opb;
   end

   always_comb begin
      logic [CW-1:0] va, vb, vc, mn, mx;
      for (int k = 0; k < 3; k++) begin
         va = in_data[k*CW +: CW];
         vb = in_data[(3+k)*CW +: CW];
         vc = in_data[(6+k)*CW +: CW];
         mn = min_ff[k];
         mx = max_ff[k];
         if ($signed(va) < $signed(mn)) mn = va;
         if ($signed(vb) < $signed(mn)) mn = vb;
         if ($signed(vc) < $signed(mn)) mn = vc;
         if ($signed(va) > $signed(mx)) mx = va;
         if ($signed(vb) > $signed(mx)) mx = vb;
         if ($signed(vc) > $signed(mx)) mx = vc;
         min_in[k] = mn;
         max_in[k] = mx;
      end
   end

   // multiply by (4^k-1)/3 as a product of (1 + 4^(2^j)), then add x back
   always_comb begin
      p_add = PW'(x_ff);
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (div_idx_ff == IDX_W'(j)) p_add = p_ff << (2 << j);
      end
   end

   assign r_sh = {rem_ff[RW:0], rad_ff[2*RW-1 -: 2]};
   assign r_try = {1'b0, root_ff, 2'b01};
   assign vmag = acc_ff[AW-1] ? (~acc_ff + AW'(1)) : acc_ff;
   assign vsum = vmag + AW'(mavb_pkg::VOL_HALF);

   always_comb begin
      rp = {1'b0, root_ff} + (RW+1)'(1);
      aext = AW'(rp[RW:1]);
      asat = |aext[AW-1:63];
      aterm = asat ? mavb_pkg::MAG_MAX : aext[62:0];
      qext = AW'(p_ff[PW-1:KW]);
      vsat = |qext[AW-1:63];
      vterm = vsat ? mavb_pkg::MAG_MAX : qext[62:0];

      area_sum = {1'b0, area_ff} + {1'b0, aterm};
      aclamp = area_sum > {1'b0, mavb_pkg::MAG_MAX};
      area_new = aclamp ? mavb_pkg::MAG_MAX : area_sum[62:0];

      vclamp = 1'b0;
      if (!vneg_ff) begin
         vs = {{2{vol_ff[63]}}, vol_ff} + {3'b000, vterm};
         if ($signed(vs) > $signed(MAX66)) begin
            vclamp = 1'b1;
            vs = MAX66;
         end
      end else begin
         vs = {{2{vol_ff[63]}}, vol_ff} - {3'b000, vterm};
         if ($signed(vs) < -$signed(MAX66)) begin
            vclamp = 1'b1;
            vs = ~MAX66 + 66'd1;
         end
      end
      vol_new = vs[63:0];
      vol_abs = vol_new[63] ? (~vol_new + 64'd1) : vol_new;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            a_ff[k] <= in_data[k*CW +: CW];
            b_ff[k] <= in_data[(3+k)*CW +: CW];
            c_ff[k] <= in_data[(6+k)*CW +: CW];
            e1_ff[k] <= {in_data[(3+k)*CW+CW-1], in_data[(3+k)*CW +: CW]}
                        - {in_data[k*CW+CW-1], in_data[k*CW +: CW]};
            e2_ff[k] <= {in_data[(6+k)*CW+CW-1], in_data[(6+k)*CW +: CW]}
                        - {in_data[k*CW+CW-1], in_data[k*CW +: CW]};
         end
         last_ff <= in_last;
      end
      if (cmd.mul_load) begin
         mcand_ff <= AW'(ma);
         mplier_ff <= mb;
         msub_ff <= opa[OW-1] ^ opb[OW-1] ^ info.neg;
         if (info.clr) acc_ff <= '0;
      end
      if (cmd.mul_run) begin
         if (mplier_ff[0]) begin
            acc_ff <= msub_ff ? (acc_ff - mcand_ff) : (acc_ff + mcand_ff);
         end
         mcand_ff <= {mcand_ff[AW-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[OW-1:1]};
      end
      if (cmd.mul_wb) begin
         case (info.dst)
            mavb_pkg::DST_N0:  n_ff[0] <= acc_ff[OW-1:0];
            mavb_pkg::DST_N1:  n_ff[1] <= acc_ff[OW-1:0];
            mavb_pkg::DST_N2:  n_ff[2] <= acc_ff[OW-1:0];
            mavb_pkg::DST_NSQ: nsq_ff <= acc_ff;
            default: ;
         endcase
      end
      if (cmd.div_init) begin
         vneg_ff <= acc_ff[AW-1];
         x_ff <= vsum[XW+mavb_pkg::VOL_SHIFT-1:mavb_pkg::VOL_SHIFT];
         p_ff <= PW'(vsum[XW+mavb_pkg::VOL_SHIFT-1:mavb_pkg::VOL_SHIFT]);
         div_idx_ff <= '0;
      end
      if (cmd.div_run) begin
         p_ff <= p_ff + p_add;
         div_idx_ff <= div_idx_ff + IDX_W'(1);
      end
      if (cmd.sqrt_init) begin
         rad_ff <= (2*RW)'(nsq_ff);
      end
      if (cmd.sqrt_run) begin
         rad_ff <= {rad_ff[2*RW-3:0], 2'b00};
      end
      if (cmd.emit) begin
         out_area <= area_new;
         out_volume <= vol_abs[62:0];
         out_sat <= sat_ff | asat | vsat | aclamp | vclamp;
         for (int k = 0; k < 3; k++) begin
            out_min[k] <= min_ff[k];
            out_max[k] <= max_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff <= '0;
         vol_ff <= '0;
         sat_ff <= 1'b0;
         rem_ff <= '0;
         root_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            min_ff[k] <= COORD_MAX;
            max_ff[k] <= COORD_MIN;
         end
      end else begin
         if (cmd.load) begin
            for (int k = 0; k < 3; k++) begin
               min_ff[k] <= min_in[k];
               max_ff[k] <= max_in[k];
            end
         end
         if (cmd.sqrt_init) begin
            rem_ff <= '0;
            root_ff <= '0;
         end
         if (cmd.sqrt_run) begin
            if (r_sh >= r_try) begin
               rem_ff <= r_sh - r_try;
               root_ff <= {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_ff <= r_sh;
               root_ff <= {root_ff[RW-2:0], 1'b0};
            end
         end
         if (cmd.acc) begin
            if (cmd.emit) begin
               area_ff <= '0;
               vol_ff <= '0;
               sat_ff <= 1'b0;
               for (int k = 0; k < 3; k++) begin
                  min_ff[k] <= COORD_MAX;
                  max_ff[k] <= COORD_MIN;
               end
            end else begin
               area_ff <= area_new;
               vol_ff <= vol_new;
               sat_ff <= sat_ff | asat | vsat | aclamp | vclamp;
            end
         end
         if (cmd.emit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign status.last = last_ff;
   assign status.out_free = ~rsp_tvalid_ff | rsp_tready;

   `MAVB_NEVER(a_vol_floor, clock, reset, vol_ff == 64'h8000_0000_0000_0000)
   `MAVB_NEVER(a_sqrt_rem, clock, reset, rem_ff > (RW+3)'({root_ff, 1'b0}))
   `MAVB_NEVER(a_emit_blocked, clock, reset, cmd.emit && rsp_tvalid_ff && !rsp_tready)

endmodule

FILE: hw/rtl/mesh_area_volume_bounds.sv
`timescale 1ns / 1ps
// Triangle mesh surface area, signed volume and bounding box. Each transfer on req_ carries one
// triangle; the one with req_tlast high closes the part and yields one rsp_ transfer with the
// area total, the absolute volume total, the box over all used vertices and a saturation flag,
// after which all totals start over. Each triangle runs through a bit-serial multiplier for 18
// products over 2*COORD_WIDTH+2 multiplier bits each, then a bit-serial square root giving a
// 2*COORD_WIDTH+3-bit root and a short shift-and-add divide by three. A finished result waits
// in an output register while the next triangle is already accepted.
module mesh_area_volume_bounds #(
   parameter int COORD_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
   // vertex_c_x, vertex_c_y, vertex_c_z
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // area, enclosed_volume, box_min_x, box_min_y, box_min_z,
   // box_max_x, box_max_y, box_max_z, saturated
   output logic [((6*COORD_WIDTH+127+7)/8)*8-1:0] rsp_tdata
);

   localparam int CW = COORD_WIDTH;
   localparam int OUT_W = 6 * CW + 127;
   localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

   mavb_pkg::cmd_type    cmd;
   mavb_pkg::status_type status;
   logic [62:0]          out_area;
   logic [62:0]          out_volume;
   logic [CW-1:0]        out_min [3];
   logic [CW-1:0]        out_max [3];
   logic                 out_sat;

   mavb_ctrl #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   mavb_datapath #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .in_data(req_tdata[9*CW-1:0]),
      .in_last(req_tlast),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .out_area(out_area),
      .out_volume(out_volume),
      .out_min(out_min),
      .out_max(out_max),
      .out_sat(out_sat)
   );

   assign rsp_tdata = OUT_TW'({out_sat, out_max[2], out_max[1], out_max[0],
                               out_min[2], out_min[1], out_min[0], out_volume, out_area});

endmodule
